// ===== hw/rtl/bhp_pkg.sv =====
// Shared types and constants for the bit-field header packer/unpacker.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package bhp_pkg;

    localparam int MaxFields = 32;
    localparam int MaxWidth  = 63;
    localparam int HdrBytes  = 256;

    // command codes
    localparam logic [2:0] CMD_SET_WIDTH = 3'd0;
    localparam logic [2:0] CMD_CLEAR     = 3'd1;
    localparam logic [2:0] CMD_WRITE     = 3'd2;
    localparam logic [2:0] CMD_READ      = 3'd3;
    localparam logic [2:0] CMD_LOAD      = 3'd4;

    // configuration register indexes
    localparam logic CFG_NUM_FIELDS = 1'b0;
    localparam logic CFG_LEN_INDEX  = 1'b1;

    // result kinds
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_FIELD = 1'b1;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        tbl_ok;       // item_index names a field of the table
        logic [7:0]  item_index;
        logic [5:0]  field_width;
        logic [62:0] field_value;
        logic [7:0]  byte_in;
        logic        last_byte;
    } cmd_item_t;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       clr;
        logic [8:0] clr_limit;
        logic [7:0] raddr;
    } store_req_t;

    typedef struct packed {
        logic [7:0] data;
        logic       written;
    } store_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bhp_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on bhp_pkg.
`default_nettype none
module bhp_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        cmd,
    input  wire logic [7:0]        item_index,
    input  wire logic [5:0]        field_width,
    input  wire logic [62:0]       field_value,
    input  wire logic [7:0]        byte_in,
    input  wire logic              last_byte,
    output logic                   head_valid,
    output bhp_pkg::cmd_item_t     head,
    input  wire logic              pop
);

    bhp_pkg::cmd_item_t q_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    bhp_pkg::cmd_item_t incoming;

    assign in_stall   = (cnt_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rp_reg];

    always_comb
    begin
        incoming.cmd         = cmd;
        incoming.tbl_ok      = (item_index < 8'(bhp_pkg::MaxFields));
        incoming.item_index  = item_index;
        incoming.field_width = field_width;
        incoming.field_value = field_value;
        incoming.byte_in     = byte_in;
        incoming.last_byte   = last_byte;
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= incoming;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bhp_store.sv =====
// Header byte store: 256 x 8 memory with one written flag per byte.
// Depends on bhp_pkg.
`default_nettype none
module bhp_store (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bhp_pkg::store_req_t req,
    output bhp_pkg::store_rsp_t      rsp
);

    logic [7:0] mem [bhp_pkg::HdrBytes];
    logic [bhp_pkg::HdrBytes-1:0] written_reg;
    logic [7:0] rdata_reg;
    logic       rwritten_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    // drop the written flag of every byte below the clear limit back to its reset value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg  <= '0;
            rwritten_reg <= 1'b0;
        end
        else
        begin
            rwritten_reg <= written_reg[req.raddr];
            for (int i = 0; i < bhp_pkg::HdrBytes; i++)
            begin
                if (req.clr && (9'(i) < req.clr_limit))
                begin
                    written_reg[i] <= 1'b0;
                end
                else if (req.we && (req.waddr == 8'(i)))
                begin
                    written_reg[i] <= 1'b1;
                end
            end
        end
    end

    assign rsp.data    = rdata_reg;
    assign rsp.written = rwritten_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bhp_back.sv =====
// Back end: sequencer that runs each queued command against the width table
// and the byte store, and drives the result register. Depends on bhp_pkg.
`default_nettype none
module bhp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                head_valid,
    input  wire bhp_pkg::cmd_item_t  head,
    output logic                     pop,
    input  wire logic [5:0]          nf_use,
    input  wire logic [4:0]          len_index,
    output bhp_pkg::store_req_t      sreq,
    input  wire bhp_pkg::store_rsp_t srsp,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     result_kind,
    output logic [7:0]               result_index,
    output logic [62:0]              result_value,
    output logic                     field_valid,
    output logic [7:0]               header_bytes,
    output logic                     last_result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SUM   = 4'd1;
    localparam logic [3:0] S_WPREP = 4'd2;
    localparam logic [3:0] S_WRD   = 4'd3;
    localparam logic [3:0] S_WMRG  = 4'd4;
    localparam logic [3:0] S_RRD   = 4'd5;
    localparam logic [3:0] S_REMIT = 4'd6;
    localparam logic [3:0] S_FLD   = 4'd7;
    localparam logic [3:0] S_URD   = 4'd8;
    localparam logic [3:0] S_UACC  = 4'd9;
    localparam logic [3:0] S_UEXT  = 4'd10;
    localparam logic [3:0] S_UEMIT = 4'd11;

    logic [3:0]  state_reg;
    bhp_pkg::cmd_item_t cur_reg;
    logic [5:0]  width_reg [bhp_pkg::MaxFields];
    logic [5:0]  i_reg, end_reg;
    logic [10:0] acc_reg, total_bits_reg;
    logic [8:0]  limit_reg;
    logic        poison_reg, ok_reg;
    logic [10:0] s_reg;
    logic [5:0]  w_reg;
    logic [3:0]  k_reg, nb_reg;
    logic [8:0]  base_reg;
    logic [71:0] win_reg, mask_reg;
    logic [62:0] val_reg;
    logic        hi_reg;

    logic        out_free;
    logic [11:0] tb_sum, acc_sum;
    logic [8:0]  hb, hb_acc;
    logic [8:0]  addr_cur;
    logic [7:0]  rbyte;
    logic [5:0]  w_cur, w_fld;
    logic [63:0] mask_w, mask_f;
    logic [6:0]  wsh, usum, ush;
    logic [2:0]  off;
    logic [11:0] fend;
    logic        fok;
    logic [71:0] wshift, ushift;

    assign tb_sum   = {1'b0, total_bits_reg} + 12'd7;
    assign hb       = tb_sum[11:3];
    assign acc_sum  = {1'b0, acc_reg} + 12'd7;
    assign hb_acc   = acc_sum[11:3];
    assign out_free = !out_valid || !out_stall;
    assign addr_cur = base_reg + {5'd0, k_reg};
    assign rbyte    = (!hi_reg && srsp.written) ? srsp.data : 8'd0;

    assign w_cur  = width_reg[cur_reg.item_index[4:0]];
    assign w_fld  = width_reg[i_reg[4:0]];
    assign mask_w = (64'd1 << w_cur) - 64'd1;
    assign mask_f = (64'd1 << w_reg) - 64'd1;
    assign off    = acc_reg[2:0];
    assign wsh    = 7'd72 - {1'b0, w_cur} - {4'd0, off};
    assign wshift = {9'd0, cur_reg.field_value & mask_w[62:0]} << wsh;
    assign fend   = {1'b0, s_reg} + {6'd0, w_fld};
    assign fok    = !poison_reg && (fend <= {limit_reg, 3'b000});
    assign usum   = {3'd0, k_reg} << 3;
    assign ush    = usum - {4'd0, s_reg[2:0]} - {1'b0, w_reg};
    assign ushift = win_reg >> ush;

    assign pop = (state_reg == S_IDLE) && head_valid;

    always_comb
    begin
        sreq           = '0;
        sreq.raddr     = addr_cur[7:0];
        if (state_reg == S_IDLE && head_valid && head.cmd == bhp_pkg::CMD_LOAD)
        begin
            sreq.we    = 1'b1;
            sreq.waddr = head.item_index;
            sreq.wdata = head.byte_in;
        end
        // hold the read address while the byte waits for the result register
        if (state_reg == S_RRD || state_reg == S_REMIT)
        begin
            sreq.raddr = cur_reg.item_index;
        end
        if (state_reg == S_WMRG)
        begin
            sreq.we    = !addr_cur[8];
            sreq.waddr = addr_cur[7:0];
            sreq.wdata = (rbyte & ~mask_reg[71:64]) | (win_reg[71:64] & mask_reg[71:64]);
        end
        if (state_reg == S_SUM && i_reg == end_reg && cur_reg.cmd == bhp_pkg::CMD_CLEAR)
        begin
            sreq.clr       = 1'b1;
            sreq.clr_limit = hb_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            total_bits_reg <= '0;
            limit_reg      <= '0;
            out_valid      <= 1'b0;
            for (int j = 0; j < bhp_pkg::MaxFields; j++)
            begin
                width_reg[j] <= '0;
            end
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (head_valid)
                    begin
                        cur_reg <= head;
                        i_reg   <= '0;
                        acc_reg <= '0;
                        case (head.cmd)
                            bhp_pkg::CMD_SET_WIDTH:
                            begin
                                if (head.tbl_ok)
                                begin
                                    width_reg[head.item_index[4:0]] <=
                                        head.field_width;
                                end
                            end
                            bhp_pkg::CMD_CLEAR:
                            begin
                                end_reg   <= nf_use;
                                state_reg <= S_SUM;
                            end
                            bhp_pkg::CMD_WRITE:
                            begin
                                if (head.tbl_ok)
                                begin
                                    end_reg   <= head.item_index[5:0];
                                    state_reg <= S_SUM;
                                end
                            end
                            bhp_pkg::CMD_READ:
                            begin
                                state_reg <= S_RRD;
                            end
                            bhp_pkg::CMD_LOAD:
                            begin
                                if (head.last_byte && nf_use != 6'd0)
                                begin
                                    limit_reg  <= hb;
                                    poison_reg <= 1'b0;
                                    s_reg      <= '0;
                                    state_reg  <= S_FLD;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SUM:
                begin
                    if (i_reg == end_reg)
                    begin
                        if (cur_reg.cmd == bhp_pkg::CMD_CLEAR)
                        begin
                            total_bits_reg <= acc_reg;
                            limit_reg      <= hb_acc;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_WPREP;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_reg + {5'd0, w_fld};
                        i_reg   <= i_reg + 6'd1;
                    end
                end
                S_WPREP:
                begin
                    // left-justify the field and its mask in a 9-byte window
                    win_reg   <= wshift;
                    mask_reg  <= {8'd0, mask_w} << wsh;
                    base_reg  <= {1'b0, acc_reg[10:3]};
                    nb_reg    <= 4'(({4'd0, off} + {1'b0, w_cur} + 7'd7) >> 3);
                    k_reg     <= '0;
                    state_reg <= S_WRD;
                end
                S_WRD:
                begin
                    hi_reg    <= addr_cur[8];
                    state_reg <= (k_reg == nb_reg) ? S_IDLE : S_WMRG;
                end
                S_WMRG:
                begin
                    win_reg   <= win_reg << 8;
                    mask_reg  <= mask_reg << 8;
                    k_reg     <= k_reg + 4'd1;
                    state_reg <= S_WRD;
                end
                S_RRD:
                begin
                    hi_reg    <= 1'b0;
                    state_reg <= S_REMIT;
                end
                S_REMIT:
                begin
                    if (out_free)
                    begin
                        out_valid    <= 1'b1;
                        result_kind  <= bhp_pkg::KIND_BYTE;
                        result_index <= cur_reg.item_index;
                        result_value <= {55'd0, rbyte};
                        field_valid  <= ({1'b0, cur_reg.item_index} < hb);
                        header_bytes <= hb[7:0];
                        last_result  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_FLD:
                begin
                    w_reg    <= w_fld;
                    ok_reg   <= fok;
                    val_reg  <= '0;
                    base_reg <= {1'b0, s_reg[10:3]};
                    k_reg    <= '0;
                    win_reg  <= '0;
                    nb_reg   <= 4'(({4'd0, s_reg[2:0]} + {1'b0, w_fld} + 7'd7) >> 3);
                    state_reg <= (fok && w_fld != 6'd0) ? S_URD : S_UEMIT;
                end
                S_URD:
                begin
                    hi_reg    <= addr_cur[8];
                    state_reg <= (k_reg == nb_reg) ? S_UEXT : S_UACC;
                end
                S_UACC:
                begin
                    win_reg   <= {win_reg[63:0], rbyte};
                    k_reg     <= k_reg + 4'd1;
                    state_reg <= S_URD;
                end
                S_UEXT:
                begin
                    val_reg   <= ushift[62:0] & mask_f[62:0];
                    state_reg <= S_UEMIT;
                end
                S_UEMIT:
                begin
                    if (out_free)
                    begin
                        out_valid    <= 1'b1;
                        result_kind  <= bhp_pkg::KIND_FIELD;
                        result_index <= {2'd0, i_reg};
                        result_value <= val_reg;
                        field_valid  <= ok_reg;
                        header_bytes <= hb[7:0];
                        last_result  <= (i_reg + 6'd1 == nf_use);
                        if (i_reg == {1'b0, len_index})
                        begin
                            if (!ok_reg)
                            begin
                                poison_reg <= 1'b1;
                                limit_reg  <= '0;
                            end
                            else if (val_reg != {54'd0, hb})
                            begin
                                limit_reg <= (|val_reg[62:8]) ? 9'd255
                                                              : {1'b0, val_reg[7:0]};
                            end
                        end
                        s_reg     <= s_reg + {5'd0, w_reg};
                        i_reg     <= i_reg + 6'd1;
                        state_reg <= (i_reg + 6'd1 == nf_use) ? S_IDLE : S_FLD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bitfield_header_pack_unpack.sv =====
// Top level of the MSB-first bit-field header packer/unpacker.
// Depends on bhp_pkg, bhp_front, bhp_store and bhp_back.
//
//  channel | handshake          | carries
//  --------+--------------------+-----------------------------------------------
//  in      | in_valid/in_stall  | cmd, item_index, field_width, field_value,
//          |                    | byte_in, last_byte
//  out     | out_valid/out_stall| result_kind, result_index, result_value,
//          |                    | field_valid, header_bytes, last_result
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Clear header sums the widths of the fields in use with the shared adder over the
// width table. Write field sums the widths of the fields before it, then does a
// memory read-modify-write per touched byte. Unpack reads each field byte by byte
// through the single memory read port; an invalid or empty field reads no bytes.
// Output stalls hold the back end. A two-entry queue lets items in while the back
// end works. Reset clears the width table, counters and the byte flags.
`default_nettype none
module bitfield_header_pack_unpack (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  item_index,
    input  wire logic [5:0]  field_width,
    input  wire logic [62:0] field_value,
    input  wire logic [7:0]  byte_in,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             result_kind,
    output logic [7:0]       result_index,
    output logic [62:0]      result_value,
    output logic             field_valid,
    output logic [7:0]       header_bytes,
    output logic             last_result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [5:0]  cfg_data
);

    logic [5:0] num_fields_reg;
    logic [4:0] len_index_reg;
    logic [5:0] nf_use;
    logic       head_valid, pop;
    bhp_pkg::cmd_item_t  head;
    bhp_pkg::store_req_t sreq;
    bhp_pkg::store_rsp_t srsp;

    assign cfg_ready = 1'b1;
    // clamp the field count to the table depth
    assign nf_use = (num_fields_reg > 6'(bhp_pkg::MaxFields)) ?
                    6'(bhp_pkg::MaxFields) : num_fields_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_fields_reg <= 6'd1;
            len_index_reg  <= 5'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bhp_pkg::CFG_NUM_FIELDS: num_fields_reg <= cfg_data;
                bhp_pkg::CFG_LEN_INDEX:  len_index_reg  <= cfg_data[4:0];
                default:                 num_fields_reg <= num_fields_reg;
            endcase
        end
    end

    bhp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .item_index  (item_index),
        .field_width (field_width),
        .field_value (field_value),
        .byte_in     (byte_in),
        .last_byte   (last_byte),
        .head_valid  (head_valid),
        .head        (head),
        .pop         (pop)
    );

    bhp_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rsp   (srsp)
    );

    bhp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .nf_use       (nf_use),
        .len_index    (len_index_reg),
        .sreq         (sreq),
        .srsp         (srsp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .result_index (result_index),
        .result_value (result_value),
        .field_valid  (field_valid),
        .header_bytes (header_bytes),
        .last_result  (last_result)
    );

endmodule
`default_nettype wire

// ===== tb/tb_bitfield_header_pack_unpack.sv =====
// Self-checking testbench for bitfield_header_pack_unpack: directed and random
// command streams, checked against an in-bench model of the header store.
// Depends on bhp_pkg and the RTL of the block; nothing else.
`default_nettype none
module tb_bitfield_header_pack_unpack;

    // Commands the block ignores
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int SettleCycles = 1500;  // longest resultless work still in flight
    localparam int IdleLimit    = 20000; // cycles without any handshake
    localparam int RandomItems  = 175;   // random rounds stop once this many are sent

    typedef struct {
        logic        kind;
        logic [7:0]  idx;
        logic [62:0] val;
        logic        ok;
        logic [7:0]  hbytes;
        logic        last;
    } hdr_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  cmd = bhp_pkg::CMD_SET_WIDTH;
    logic [7:0]  item_index = '0;
    logic [5:0]  field_width = '0;
    logic [62:0] field_value = '0;
    logic [7:0]  byte_in = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        result_kind;
    logic [7:0]  result_index;
    logic [62:0] result_value;
    logic        field_valid;
    logic [7:0]  header_bytes;
    logic        last_result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = bhp_pkg::CFG_NUM_FIELDS;
    logic [5:0]  cfg_data = '0;

    bitfield_header_pack_unpack u_top (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Model state of the header block
    logic [5:0]  width_tbl [bhp_pkg::MaxFields];
    logic [7:0]  hdr_mem [bhp_pkg::HdrBytes];
    logic [10:0] sum_bits;
    logic [5:0]  fields_cfg;
    logic [4:0]  len_field;

    hdr_result_t expected_results [$];

    int  items_sent     = 0;
    int  results_seen   = 0;
    int  unpacks_run    = 0;
    int  mismatches     = 0;
    int  idle_cycles    = 0;
    bit  tx_no_gaps     = 0;
    bit  rx_no_stalls   = 0;
    int  rx_hold_req    = 0;

    function automatic int hdr_size_now();
        return (int'(sum_bits) + 7) >> 3;
    endfunction

    function automatic int used_fields();
        return (fields_cfg > bhp_pkg::MaxFields) ? bhp_pkg::MaxFields : int'(fields_cfg);
    endfunction

    function automatic int field_start(int fidx);
        int s;
        s = 0;
        for (int i = 0; i < fidx && i < bhp_pkg::MaxFields; i++)
            s += width_tbl[i];
        return s;
    endfunction

    function automatic logic hdr_bit(int pos);
        if ((pos >> 3) >= bhp_pkg::HdrBytes)
            return 1'b0;
        return hdr_mem[pos >> 3][7 - (pos & 7)];
    endfunction

    function automatic void push_result(logic kind, int idx, logic [62:0] val, logic ok);
        hdr_result_t r;
        r.kind   = kind;
        r.idx    = idx[7:0];
        r.val    = val;
        r.ok     = ok;
        r.hbytes = 8'(hdr_size_now());
        r.last   = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Advance the model by one accepted item and queue the results it causes
    function automatic void model_header_cmd(logic [2:0] c, logic [7:0] idx, logic [5:0] fw,
                                             logic [62:0] fv, logic [7:0] bi, logic lb);
        int          s, w, hb, lim, n0, nf;
        bit          poisoned, ok;
        logic [62:0] v;
        n0 = expected_results.size();
        case (c)
            bhp_pkg::CMD_SET_WIDTH:
                if (idx < bhp_pkg::MaxFields)
                    width_tbl[idx] = (fw > bhp_pkg::MaxWidth) ? 6'(bhp_pkg::MaxWidth) : fw;
            bhp_pkg::CMD_CLEAR:
            begin
                s = field_start(used_fields());
                sum_bits = (s > 2047) ? 11'd2047 : s[10:0];
                hb = hdr_size_now();
                for (int i = 0; i < hb && i < bhp_pkg::HdrBytes; i++)
                    hdr_mem[i] = 8'h00;
            end
            bhp_pkg::CMD_WRITE:
                if (idx < bhp_pkg::MaxFields)
                begin
                    w = width_tbl[idx];
                    s = field_start(idx);
                    for (int b = 0; b < w; b++)
                        if (((s + b) >> 3) < bhp_pkg::HdrBytes)
                            hdr_mem[(s + b) >> 3][7 - ((s + b) & 7)] = fv[w - 1 - b];
                end
            bhp_pkg::CMD_READ:
                push_result(bhp_pkg::KIND_BYTE, idx, {55'd0, hdr_mem[idx]},
                            idx < hdr_size_now());
            bhp_pkg::CMD_LOAD:
            begin
                hdr_mem[idx] = bi;
                if (lb)
                begin
                    nf = used_fields();
                    hb = hdr_size_now();
                    lim = hb;
                    poisoned = 0;
                    s = 0;
                    for (int i = 0; i < nf; i++)
                    begin
                        w = width_tbl[i];
                        ok = !poisoned && (s + w <= lim * 8);
                        v = '0;
                        if (ok)
                            for (int b = 0; b < w; b++)
                                v = {v[61:0], hdr_bit(s + b)};
                        if (i == len_field)
                        begin
                            if (!ok)
                            begin
                                poisoned = 1;
                                lim = 0;
                            end
                            else if (v != 63'(hb))
                                lim = (v > 255) ? 255 : int'(v);
                        end
                        push_result(bhp_pkg::KIND_FIELD, i, v, ok);
                        s += w;
                    end
                    unpacks_run++;
                end
            end
            default: ;
        endcase
        if (expected_results.size() > n0)
            expected_results[$].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one item, hold it until accepted, then update the model
    task automatic send_item(logic [2:0] c, logic [7:0] idx, logic [5:0] fw,
                             logic [62:0] fv, logic [7:0] bi, logic lb);
        int gap;
        gap = tx_no_gaps ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        cmd         <= c;
        item_index  <= idx;
        field_width <= fw;
        field_value <= fv;
        byte_in     <= bi;
        last_byte   <= lb;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        model_header_cmd(c, idx, fw, fv, bi, lb);
    endtask

    // Drop valid and wait for every queued result, then let resultless work settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_cfg(logic ri, logic [5:0] val);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (ri == bhp_pkg::CFG_NUM_FIELDS)
            fields_cfg = val;
        else
            len_field = val[4:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [62:0] rand63();
        return 63'({$urandom, $urandom});
    endfunction

    // Receiver: random stalls, plus a long counted hold on request
    always
    begin
        int stall_left;
        @(negedge clk);
        if (rx_hold_req > 0)
        begin
            out_stall <= 1'b1;
            rx_hold_req--;
        end
        else if (rx_no_stalls)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if ($urandom_range(99) < 25)
        begin
            stall_left = ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(40, 10);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge clk)
    begin
        hdr_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d index %0d value %h",
                             result_kind, result_index, result_value);
            end
            else
            begin
                e = expected_results.pop_front();
                if (e.kind !== result_kind || e.idx !== result_index ||
                    e.val !== result_value || e.ok !== field_valid ||
                    e.hbytes !== header_bytes || e.last !== last_result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp kind %0d idx %0d val %h ok %0d hb %0d last %0d",
                                 e.kind, e.idx, e.val, e.ok, e.hbytes, e.last,
                                 " / got kind %0d idx %0d val %h ok %0d hb %0d last %0d",
                                 result_kind, result_index, result_value, field_valid,
                                 header_bytes, last_result);
                end
            end
        end
    end

    // Watchdog: end the run if no handshake happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("watchdog expired with %0d results outstanding", expected_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Small layout with every width class; pack, read back and poke the edges
    task automatic test_pack_directed();
        write_cfg(bhp_pkg::CFG_NUM_FIELDS, 6'd5);
        write_cfg(bhp_pkg::CFG_LEN_INDEX, 6'd0);
        tx_no_gaps = 1;
        send_item(bhp_pkg::CMD_SET_WIDTH, 8'd0, 6'd8, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_SET_WIDTH, 8'd1, 6'd63, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_SET_WIDTH, 8'd2, 6'd0, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_SET_WIDTH, 8'd3, 6'd5, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_SET_WIDTH, 8'd4, 6'd1, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_SET_WIDTH, 8'd255, 6'd63, '0, 8'h00, 1'b0); // out of table
        tx_no_gaps = 0;
        send_item(bhp_pkg::CMD_CLEAR, 8'd0, '0, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_WRITE, 8'd0, '0, 63'd10, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_WRITE, 8'd1, '0, '1, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_WRITE, 8'd2, '0, '1, 8'h00, 1'b0);       // zero width
        send_item(bhp_pkg::CMD_WRITE, 8'd3, '0, '1, 8'h00, 1'b0);       // masked to 5 bits
        send_item(bhp_pkg::CMD_WRITE, 8'd4, '0, 63'd1, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_WRITE, 8'd200, '0, '1, 8'hFF, 1'b1);     // out of table
        send_item(CMD_SPARE5, 8'hFF, '1, '1, 8'hFF, 1'b1);
        send_item(CMD_SPARE6, 8'hFF, '1, '1, 8'hFF, 1'b1);
        send_item(CMD_SPARE7, 8'hFF, '1, '1, 8'hFF, 1'b1);
        send_item(bhp_pkg::CMD_READ, 8'd0, '0, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_READ, 8'd9, '0, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_READ, 8'd10, '0, '0, 8'h00, 1'b0);       // past the header
        send_item(bhp_pkg::CMD_READ, 8'd255, '0, '0, 8'h00, 1'b0);
    endtask

    // Unpack with a short length, a stale layout that poisons the length field,
    // and an empty layout
    task automatic test_unpack_directed();
        send_item(bhp_pkg::CMD_LOAD, 8'd0, '0, '0, 8'd4, 1'b0);         // length below header
        send_item(bhp_pkg::CMD_LOAD, 8'd9, '0, '0, 8'hA5, 1'b1);
        send_item(bhp_pkg::CMD_LOAD, 8'd0, '0, '0, 8'd255, 1'b1);       // length at its 255 cap
        send_item(bhp_pkg::CMD_SET_WIDTH, 8'd0, 6'd63, '0, 8'h00, 1'b0); // layout past header
        write_cfg(bhp_pkg::CFG_LEN_INDEX, 6'd1);
        send_item(bhp_pkg::CMD_LOAD, 8'd255, '0, '0, 8'h5A, 1'b1);
        write_cfg(bhp_pkg::CFG_LEN_INDEX, 6'd31);
        write_cfg(bhp_pkg::CFG_NUM_FIELDS, 6'd0);
        send_item(bhp_pkg::CMD_LOAD, 8'd3, '0, '0, 8'hFF, 1'b1);        // no fields, no result
        send_item(bhp_pkg::CMD_CLEAR, 8'd0, '0, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_READ, 8'd0, '0, '0, 8'h00, 1'b0);
    endtask

    // One well-formed round: layout, clear, pack, read back, reload and unpack
    task automatic header_round();
        int nf, hb, nload;
        nf = used_fields();
        for (int i = 0; i < nf; i++)
            send_item(bhp_pkg::CMD_SET_WIDTH, i[7:0],
                      ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(12)),
                      '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_CLEAR, 8'($urandom), '0, '0, 8'h00, 1'b0);
        for (int i = 0; i < nf && i < 6; i++)
            send_item(bhp_pkg::CMD_WRITE, 8'($urandom_range(nf - 1)), '0, rand63(),
                      8'h00, 1'b0);
        hb = hdr_size_now();
        for (int i = 0; i < 3; i++)
            send_item(bhp_pkg::CMD_READ, 8'($urandom_range(hb + 1)), '0, '0, 8'h00, 1'b0);
        nload = (hb < 4) ? hb : 4;
        for (int i = 0; i < nload; i++)
            send_item(bhp_pkg::CMD_LOAD, i[7:0], '0, '0, 8'($urandom), 1'b0);
        send_item(bhp_pkg::CMD_LOAD, 8'($urandom_range(hb)), '0, '0, 8'($urandom), 1'b1);
    endtask

    task automatic noise_item();
        send_item(3'($urandom_range(7)), 8'($urandom), 6'($urandom), rand63(),
                  8'($urandom), 1'($urandom));
    endtask

    // Random rounds under changing layouts, with noise in between
    task automatic test_random_rounds();
        int fields_pick;
        while (items_sent < RandomItems)
        begin
            case ($urandom_range(5))
                0: fields_pick = 1;
                1: fields_pick = 32;
                2: fields_pick = 63;
                3: fields_pick = $urandom_range(40, 33);
                default: fields_pick = $urandom_range(8, 1);
            endcase
            write_cfg(bhp_pkg::CFG_NUM_FIELDS, fields_pick[5:0]);
            write_cfg(bhp_pkg::CFG_LEN_INDEX,
                      ($urandom_range(3) == 0) ? 6'd31 : 6'($urandom_range(3)));
            tx_no_gaps   = ($urandom_range(3) == 0);
            rx_no_stalls = ($urandom_range(3) == 0);
            for (int k = 0; k < 2 && items_sent < RandomItems; k++)
            begin
                header_round();
                repeat ($urandom_range(4)) noise_item();
            end
            tx_no_gaps   = 0;
            rx_no_stalls = 0;
        end
    endtask

    // Hold the receiver for a long stretch while reads keep coming, then let the
    // sender pause until everything has drained
    task automatic test_backpressure();
        write_cfg(bhp_pkg::CFG_NUM_FIELDS, 6'd4);
        rx_hold_req = 400;
        for (int i = 0; i < 12; i++)
            send_item(bhp_pkg::CMD_READ, 8'($urandom_range(15)), '0, '0, 8'h00, 1'b0);
        send_item(bhp_pkg::CMD_LOAD, 8'd1, '0, '0, 8'($urandom), 1'b1);
        wait_idle();
        for (int i = 0; i < 4; i++)
            send_item(bhp_pkg::CMD_READ, 8'($urandom), '0, '0, 8'h00, 1'b0);
    endtask

    initial
    begin
        foreach (width_tbl[i]) width_tbl[i] = '0;
        foreach (hdr_mem[i]) hdr_mem[i] = '0;
        sum_bits   = '0;
        fields_cfg = 6'd1;
        len_field  = 5'd0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        test_pack_directed();
        test_unpack_directed();
        test_random_rounds();
        test_backpressure();
        wait_idle();

        $display("sent %0d items, checked %0d results over %0d unpacks",
                 items_sent, results_seen, unpacks_run);
        $display("layouts of 0 to 63 fields, stalls and a long receiver hold included");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
